/* rtl/soac_pkg.sv */
// ---------------------------------------------------------------------------
// soac_pkg
// Types and constants shared by the sonar obstacle avoiding controller.
// ---------------------------------------------------------------------------
package soac_pkg;

    // item kinds on the slave stream tuser
    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_STOPPED     = 3'd0,
        ST_RUN         = 3'd1,
        ST_SCAN_CENTER = 3'd2,
        ST_SCAN_LEFT   = 3'd3,
        ST_SCAN_RIGHT  = 3'd4,
        ST_BACK        = 3'd5,
        ST_TURN_LEFT   = 3'd6,
        ST_TURN_RIGHT  = 3'd7
    } t_ctl_state;

    // motor commands
    typedef enum logic [2:0] {
        CMD_STOP  = 3'd0,
        CMD_RUN   = 3'd1,
        CMD_BACK  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4
    } t_motor_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_NEAR_ON   = 3'd0,
        CFG_NEAR_OFF  = 3'd1,
        CFG_SAFE      = 3'd2,
        CFG_FAST      = 3'd3,
        CFG_SPIKE     = 3'd4,
        CFG_SETTLE    = 3'd5,
        CFG_BACK      = 3'd6,
        CFG_TURN      = 3'd7
    } t_cfg_idx;

    // echo pulse limits and conversion
    localparam logic [31:0] PULSE_MIN_US = 32'd150;
    localparam logic [31:0] PULSE_MAX_US = 32'd25000;
    // floor(w / 58) == (w * 18079) >> 20 for every w up to 25000
    localparam logic [14:0] DIV58_MUL    = 15'd18079;
    localparam int          DIV58_SHIFT  = 20;

    // servo pulse widths
    localparam logic [10:0] SERVO_MID = 11'd1500;
    localparam logic [10:0] SERVO_L   = 11'd2000;
    localparam logic [10:0] SERVO_R   = 11'd1000;

    // speed steps
    localparam logic [1:0] SPEED_0 = 2'd0;
    localparam logic [1:0] SPEED_1 = 2'd1;
    localparam logic [1:0] SPEED_2 = 2'd2;

    // measured event handed from the echo stage to the control stage
    typedef struct packed {
        logic       vld;
        t_kind      kind;
        logic       echo_ok;
        logic [8:0] cm;
    } t_echo_ev;

endpackage

/* rtl/soac_echo.sv */
// ---------------------------------------------------------------------------
// soac_echo
// Echo pulse stage: holds the rise time, measures the width of a falling
// edge, range checks it and converts it to centimetres.
// ---------------------------------------------------------------------------
module soac_echo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_vld,
    output logic                o_in_rdy,
    input  soac_pkg::t_kind     i_kind,
    input  logic                i_level,
    input  logic [31:0]         i_time_us,
    input  logic                i_out_rdy,
    output soac_pkg::t_echo_ev  o_ev
);

    logic               r_vld;
    soac_pkg::t_kind    r_kind;
    logic               r_echo_ok;
    logic [8:0]         r_cm;
    logic [31:0]        r_rise_us;

    logic [31:0]        w_width;
    logic               w_in_range;
    logic [29:0]        w_prod;
    logic               w_load;

    // stage moves when empty or when the control stage takes it
    assign o_in_rdy = !r_vld || i_out_rdy;
    assign w_load   = i_in_vld && o_in_rdy;

    // pulse width modulo 2^32 and range check
    assign w_width    = i_time_us - r_rise_us;
    assign w_in_range = (w_width >= soac_pkg::PULSE_MIN_US) &&
                        (w_width <= soac_pkg::PULSE_MAX_US);

    // divide by 58 through a reciprocal multiply
    assign w_prod = 30'(w_width[14:0]) * 30'(soac_pkg::DIV58_MUL);

    // valid and rise time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_rise_us <= '0;
        end else begin
            if (o_in_rdy) begin
                r_vld <= i_in_vld;
            end
            if (w_load && i_kind == soac_pkg::KIND_ECHO && i_level) begin
                r_rise_us <= i_time_us;
            end
        end
    end

    // event payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind    <= i_kind;
            r_echo_ok <= (i_kind == soac_pkg::KIND_ECHO) && !i_level && w_in_range;
            r_cm      <= w_prod[soac_pkg::DIV58_SHIFT +: 9];
        end
    end

    assign o_ev.vld     = r_vld;
    assign o_ev.kind    = r_kind;
    assign o_ev.echo_ok = r_echo_ok;
    assign o_ev.cm      = r_cm;

endmodule

/* rtl/sonar_obstacle_avoid_controller.sv */
// ---------------------------------------------------------------------------
// sonar_obstacle_avoid_controller
// Ultrasonic obstacle avoiding drive controller: distance measurement with
// spike filter and near hysteresis, and a scan and avoid sequencer that
// issues motor and servo commands.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  slave    | in  | i_s_tvalid/o_s_tready| tuser: kind; tdata: echo_level,
//           |     |                      |   echo_time_us
//  master   | out | o_m_tvalid/i_m_tready| tdata: motor and servo commands,
//           |     |                      |   distance, near flag
//  config   | in  | i_cfg_we             | i_cfg_addr, i_cfg_wdata
//
// One item is taken per cycle while the master side takes results; every
// item gives one result (echo register, then control and result register).
// The pulse width subtract and the divide-by-58 multiply set the echo stage;
// the filter compares and deadline adds set the control stage.
// A master stall holds both stages; o_s_tready drops once echo holds an item.
// Reset is synchronous, active low; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sonar_obstacle_avoid_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [0] echo_level, [32:1] echo_time_us
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [0] motor_valid, [3:1] motor_cmd,
                                     // [5:4] motor_speed, [6] servo_valid,
                                     // [17:7] servo_pulse_us,
                                     // [26:18] distance_cm, [27] near
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    // configuration registers
    logic [8:0]  r_near_on, r_near_off, r_safe, r_fast, r_spike;
    logic [15:0] r_settle, r_back, r_turn;

    // control state
    soac_pkg::t_ctl_state r_state, n_state;
    logic [8:0]  r_fd, n_fd;
    logic        r_near, n_near;
    logic        r_run, n_run;
    logic [31:0] r_now, n_now;
    logic [31:0] r_deadline, n_deadline;
    logic        r_lwr, n_lwr;
    logic [1:0]  r_ls, n_ls;
    logic [8:0]  r_scan_c, n_scan_c;
    logic [8:0]  r_scan_l, n_scan_l;

    // result register
    logic        r_out_vld;
    logic        r_mv, n_mv;
    soac_pkg::t_motor_cmd r_mc, n_mc;
    logic [1:0]  r_ms, n_ms;
    logic        r_sv, n_sv;
    logic [10:0] r_sp, n_sp;

    soac_pkg::t_echo_ev w_ev;
    logic        w_s2_rdy;
    logic        w_s2_adv;
    logic [8:0]  w_diff;
    logic [31:0] w_elapsed;
    logic        w_reached;
    logic        w_ctl;
    logic [1:0]  w_speed;
    logic        w_want;

    // echo measurement stage
    soac_echo u_echo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (i_s_tvalid),
        .o_in_rdy  (o_s_tready),
        .i_kind    (soac_pkg::t_kind'(i_s_tuser)),
        .i_level   (i_s_tdata[0]),
        .i_time_us (i_s_tdata[32:1]),
        .i_out_rdy (w_s2_rdy),
        .o_ev      (w_ev)
    );

    assign w_s2_rdy = !r_out_vld || i_m_tready;
    assign w_s2_adv = w_ev.vld && w_s2_rdy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_on  <= 9'd18;
            r_near_off <= 9'd22;
            r_safe     <= 9'd25;
            r_fast     <= 9'd40;
            r_spike    <= 9'd100;
            r_settle   <= 16'd500;
            r_back     <= 16'd1000;
            r_turn     <= 16'd500;
        end else if (i_cfg_we) begin
            case (soac_pkg::t_cfg_idx'(i_cfg_addr))
                soac_pkg::CFG_NEAR_ON:  r_near_on  <= i_cfg_wdata[8:0];
                soac_pkg::CFG_NEAR_OFF: r_near_off <= i_cfg_wdata[8:0];
                soac_pkg::CFG_SAFE:     r_safe     <= i_cfg_wdata[8:0];
                soac_pkg::CFG_FAST:     r_fast     <= i_cfg_wdata[8:0];
                soac_pkg::CFG_SPIKE:    r_spike    <= i_cfg_wdata[8:0];
                soac_pkg::CFG_SETTLE:   r_settle   <= i_cfg_wdata;
                soac_pkg::CFG_BACK:     r_back     <= i_cfg_wdata;
                soac_pkg::CFG_TURN:     r_turn     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // spike filter and near hysteresis
    assign w_diff = (w_ev.cm > r_fd) ? (w_ev.cm - r_fd) : (r_fd - w_ev.cm);

    always_comb begin
        n_fd   = r_fd;
        n_near = r_near;
        if (w_ev.kind == soac_pkg::KIND_ECHO && w_ev.echo_ok) begin
            if (r_fd == 9'd0 || w_diff < r_spike) begin
                n_fd = w_ev.cm;
            end
            if (n_fd <= r_near_on) begin
                n_near = 1'b1;
            end else if (n_fd >= r_near_off) begin
                n_near = 1'b0;
            end
        end
    end

    // millisecond time, run toggle and deadline test
    assign n_now     = (w_ev.kind == soac_pkg::KIND_TICK) ? (r_now + 32'd1) : r_now;
    assign n_run     = (w_ev.kind == soac_pkg::KIND_BUTTON) ? !r_run : r_run;
    assign w_elapsed = n_now - r_deadline;
    assign w_reached = !w_elapsed[31];

    // which items run the control step
    always_comb begin
        case (w_ev.kind)
            soac_pkg::KIND_ECHO:   w_ctl = w_ev.echo_ok;
            soac_pkg::KIND_BUTTON: w_ctl = 1'b1;
            soac_pkg::KIND_TICK:   w_ctl = (r_state >= soac_pkg::ST_SCAN_CENTER) && w_reached;
            default:               w_ctl = 1'b0;
        endcase
    end

    // run speed from the filtered distance
    assign w_want  = (n_fd >= r_safe);
    assign w_speed = !w_want ? soac_pkg::SPEED_0 :
                     (n_fd > r_fast) ? soac_pkg::SPEED_2 : soac_pkg::SPEED_1;

    // control sequencer and command outputs
    always_comb begin
        n_state    = r_state;
        n_deadline = r_deadline;
        n_lwr      = r_lwr;
        n_ls       = r_ls;
        n_scan_c   = r_scan_c;
        n_scan_l   = r_scan_l;
        n_mv       = 1'b0;
        n_mc       = soac_pkg::CMD_STOP;
        n_ms       = soac_pkg::SPEED_0;
        n_sv       = 1'b0;
        n_sp       = soac_pkg::SERVO_MID;

        // button that turns driving off forces a stop
        if (w_ev.kind == soac_pkg::KIND_BUTTON && r_run) begin
            n_mv    = 1'b1;
            n_lwr   = 1'b0;
            n_ls    = soac_pkg::SPEED_0;
            n_state = soac_pkg::ST_STOPPED;
        end

        if (w_ctl) begin
            case (n_state)
                soac_pkg::ST_STOPPED: begin
                    if (n_run) begin
                        n_state = soac_pkg::ST_RUN;
                    end
                end
                soac_pkg::ST_RUN: begin
                    if (!n_run) begin
                        n_mv    = 1'b1;
                        n_state = soac_pkg::ST_STOPPED;
                    end else if (n_near) begin
                        n_mv       = 1'b1;
                        n_lwr      = 1'b0;
                        n_ls       = soac_pkg::SPEED_0;
                        n_sv       = 1'b1;
                        n_sp       = soac_pkg::SERVO_MID;
                        n_deadline = n_now + 32'(r_settle);
                        n_state    = soac_pkg::ST_SCAN_CENTER;
                    end else if (w_want != n_lwr || (w_want && w_speed != n_ls)) begin
                        n_lwr = w_want;
                        n_ls  = w_speed;
                        n_mv  = 1'b1;
                        if (w_want) begin
                            n_mc = soac_pkg::CMD_RUN;
                            n_ms = w_speed;
                        end
                    end
                end
                soac_pkg::ST_SCAN_CENTER: begin
                    if (w_reached) begin
                        n_scan_c   = n_fd;
                        n_sv       = 1'b1;
                        n_sp       = soac_pkg::SERVO_L;
                        n_deadline = n_now + 32'(r_settle);
                        n_state    = soac_pkg::ST_SCAN_LEFT;
                    end
                end
                soac_pkg::ST_SCAN_LEFT: begin
                    if (w_reached) begin
                        n_scan_l   = n_fd;
                        n_sv       = 1'b1;
                        n_sp       = soac_pkg::SERVO_R;
                        n_deadline = n_now + 32'(r_settle);
                        n_state    = soac_pkg::ST_SCAN_RIGHT;
                    end
                end
                soac_pkg::ST_SCAN_RIGHT: begin
                    if (w_reached) begin
                        n_sv = 1'b1;
                        n_sp = soac_pkg::SERVO_MID;
                        n_mv = 1'b1;
                        n_ms = soac_pkg::SPEED_1;
                        if (r_scan_c < r_safe && r_scan_l < r_safe && n_fd < r_safe) begin
                            n_mc       = soac_pkg::CMD_BACK;
                            n_deadline = n_now + 32'(r_back);
                            n_state    = soac_pkg::ST_BACK;
                        end else if (r_scan_l > n_fd) begin
                            n_mc       = soac_pkg::CMD_LEFT;
                            n_deadline = n_now + 32'(r_turn);
                            n_state    = soac_pkg::ST_TURN_LEFT;
                        end else begin
                            n_mc       = soac_pkg::CMD_RIGHT;
                            n_deadline = n_now + 32'(r_turn);
                            n_state    = soac_pkg::ST_TURN_RIGHT;
                        end
                    end
                end
                default: begin
                    // back and turn waits end in a stop
                    if (w_reached) begin
                        n_mv    = 1'b1;
                        n_mc    = soac_pkg::CMD_STOP;
                        n_ms    = soac_pkg::SPEED_0;
                        n_lwr   = 1'b0;
                        n_ls    = soac_pkg::SPEED_0;
                        n_state = n_run ? soac_pkg::ST_RUN : soac_pkg::ST_STOPPED;
                    end
                end
            endcase
        end
    end

    // state update when the control stage advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= soac_pkg::ST_STOPPED;
            r_fd       <= '0;
            r_near     <= 1'b0;
            r_run      <= 1'b0;
            r_now      <= '0;
            r_deadline <= '0;
            r_lwr      <= 1'b0;
            r_ls       <= soac_pkg::SPEED_0;
            r_scan_c   <= '0;
            r_scan_l   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_s2_rdy) begin
                r_out_vld <= w_ev.vld;
            end
            if (w_s2_adv) begin
                r_state    <= n_state;
                r_fd       <= n_fd;
                r_near     <= n_near;
                r_run      <= n_run;
                r_now      <= n_now;
                r_deadline <= n_deadline;
                r_lwr      <= n_lwr;
                r_ls       <= n_ls;
                r_scan_c   <= n_scan_c;
                r_scan_l   <= n_scan_l;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_mv <= n_mv;
            r_mc <= n_mc;
            r_ms <= n_ms;
            r_sv <= n_sv;
            r_sp <= n_sp;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'd0, r_near, r_fd, r_sp, r_sv, r_ms, r_mc, r_mv};

    // driving off always means the stopped state
    a_stop_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> r_state == soac_pkg::ST_STOPPED)
        else $error("run disabled outside stopped state");

    // no speed is remembered without a run request
    a_speed_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lwr |-> r_ls == soac_pkg::SPEED_0)
        else $error("speed held without run request");

    // once a distance is held it never returns to none
    a_dist_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_fd) != 9'd0 |-> r_fd != 9'd0)
        else $error("filtered distance dropped to none");

    // a result without a servo move carries the centre pulse
    a_servo_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_sv |-> r_sp == soac_pkg::SERVO_MID)
        else $error("servo pulse changed without servo move");

endmodule
